// ===== sv/tdc_pkg.sv =====
// Package for the configuration-text tokenizer: byte classes, token kinds,
// lexer modes and the result and push records shared by all modules.
// No dependencies.
package tdc_pkg;

  // Longest token text kept; further bytes are dropped and flagged
  localparam int MAX_TOKEN = 255;
  localparam int LEN_W     = $clog2(MAX_TOKEN + 1);

  // Character constants
  localparam logic [7:0] CH_LC_A   = 8'h61;  // 'a'
  localparam logic [7:0] CH_LC_Z   = 8'h7A;  // 'z'
  localparam logic [7:0] CH_UC_A   = 8'h41;  // 'A'
  localparam logic [7:0] CH_UC_Z   = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_0      = 8'h30;  // '0'
  localparam logic [7:0] CH_9      = 8'h39;  // '9'
  localparam logic [7:0] CH_SEMI   = 8'h3B;  // ';'
  localparam logic [7:0] CH_COMMA  = 8'h2C;  // ','
  localparam logic [7:0] CH_LBRACE = 8'h7B;  // '{'
  localparam logic [7:0] CH_RBRACE = 8'h7D;  // '}'
  localparam logic [7:0] CH_LBRACK = 8'h5B;  // '['
  localparam logic [7:0] CH_RBRACK = 8'h5D;  // ']'
  localparam logic [7:0] CH_EQUALS = 8'h3D;  // '='
  localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
  localparam logic [7:0] CH_QUOTE  = 8'h22;  // '"'
  localparam logic [7:0] CH_NL     = 8'h0A;  // newline

  // Token kinds
  localparam logic [3:0] KIND_IDENT  = 4'd0;
  localparam logic [3:0] KIND_NUMBER = 4'd1;
  localparam logic [3:0] KIND_STRING = 4'd2;
  localparam logic [3:0] KIND_SEMI   = 4'd3;
  localparam logic [3:0] KIND_COMMA  = 4'd4;
  localparam logic [3:0] KIND_LBRACE = 4'd5;
  localparam logic [3:0] KIND_RBRACE = 4'd6;
  localparam logic [3:0] KIND_LBRACK = 4'd7;
  localparam logic [3:0] KIND_RBRACK = 4'd8;
  localparam logic [3:0] KIND_EQUALS = 4'd9;
  localparam logic [3:0] KIND_MINUS  = 4'd10;
  localparam logic [3:0] KIND_EOF    = 4'd11;

  // Lexer mode, one-hot
  typedef enum logic [3:0] {
    MODE_START  = 4'b0001,
    MODE_IDENT  = 4'b0010,
    MODE_NUMBER = 4'b0100,
    MODE_STRING = 4'b1000
  } mode_t;

  // One token result, without position and run marker
  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_valid;
    logic       token_end;
    logic [3:0] token_kind;
    logic [7:0] token_length;
    logic       too_long;
  } res_t;

  localparam res_t RES_NONE = '0;

  // One result beat as queued for output
  typedef struct packed {
    res_t        res;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        last_of_run;
  } entry_t;

  // Results produced by one accepted input beat
  typedef struct packed {
    logic [1:0] count;
    entry_t     first;
    entry_t     second;
  } push_t;

  // Saturate a text length to the 8-bit length field
  function automatic logic [7:0] sat_len(input logic [LEN_W-1:0] v);
    logic [16:0] w;
    w = 17'(v);
    sat_len = (w > 17'd255) ? 8'hFF : w[7:0];
  endfunction

endpackage

// ===== sv/tdc_lexer.sv =====
// Lexer state machine: classes one byte, updates mode, length and position,
// and yields up to two results per beat. Depends on tdc_pkg.
module tdc_lexer (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_fire,
  input  logic [7:0]    char_byte,
  input  logic          end_of_input,
  output tdc_pkg::push_t push
);
  import tdc_pkg::*;

  mode_t            mode, mode_next;
  logic [LEN_W-1:0] token_len, token_len_next;
  logic             overflow_seen, overflow_seen_next;
  logic [15:0]      line_count, line_count_next;
  logic [15:0]      column_count, column_count_next;

  logic       is_letter, is_digit, is_quote, is_punct, is_other, is_eof;
  logic [3:0] punct_kind;

  logic [LEN_W-1:0] len_inc;
  logic             app_ok, ovf_app;

  res_t             st_res;
  logic             st_hit;
  mode_t            st_mode;
  logic [LEN_W-1:0] st_len;

  res_t       r0, r1;
  logic [1:0] n;

  // Byte classes
  always_comb begin
    is_eof     = end_of_input;
    is_letter  = !is_eof && (((char_byte >= CH_LC_A) && (char_byte <= CH_LC_Z)) ||
                             ((char_byte >= CH_UC_A) && (char_byte <= CH_UC_Z)));
    is_digit   = !is_eof && (char_byte >= CH_0) && (char_byte <= CH_9);
    is_quote   = !is_eof && (char_byte == CH_QUOTE);
    punct_kind = KIND_IDENT;
    is_punct   = 1'b0;
    if (!is_eof) begin
      is_punct = 1'b1;
      unique case (char_byte)
        CH_SEMI:   punct_kind = KIND_SEMI;
        CH_COMMA:  punct_kind = KIND_COMMA;
        CH_LBRACE: punct_kind = KIND_LBRACE;
        CH_RBRACE: punct_kind = KIND_RBRACE;
        CH_LBRACK: punct_kind = KIND_LBRACK;
        CH_RBRACK: punct_kind = KIND_RBRACK;
        CH_EQUALS: punct_kind = KIND_EQUALS;
        CH_MINUS:  punct_kind = KIND_MINUS;
        default:   is_punct   = 1'b0;
      endcase
    end
    is_other = !is_eof && !is_letter && !is_digit && !is_quote && !is_punct;
  end

  // Appending to the current text
  assign app_ok  = (token_len < LEN_W'(MAX_TOKEN));
  assign len_inc = app_ok ? token_len + LEN_W'(1) : token_len;
  assign ovf_app = overflow_seen | !app_ok;

  // Handling from the start state (also the second pass after a word)
  always_comb begin
    st_res  = RES_NONE;
    st_hit  = 1'b0;
    st_mode = MODE_START;
    st_len  = '0;
    if (is_eof) begin
      st_hit             = 1'b1;
      st_res.token_end   = 1'b1;
      st_res.token_kind  = KIND_EOF;
    end else if (is_letter || is_digit || is_quote) begin
      st_hit            = 1'b1;
      st_res.text_byte  = char_byte;
      st_res.text_valid = 1'b1;
      st_len            = LEN_W'(1);
      st_mode           = is_letter ? MODE_IDENT : (is_digit ? MODE_NUMBER : MODE_STRING);
    end else if (is_punct) begin
      st_hit              = 1'b1;
      st_res.text_byte    = char_byte;
      st_res.text_valid   = 1'b1;
      st_res.token_end    = 1'b1;
      st_res.token_kind   = punct_kind;
      st_res.token_length = 8'd1;
    end
  end

  // Main transition
  always_comb begin
    mode_next          = mode;
    token_len_next     = token_len;
    overflow_seen_next = overflow_seen;
    r0                 = RES_NONE;
    r1                 = RES_NONE;
    n                  = 2'd0;
    unique case (mode)
      MODE_START: begin
        r0                 = st_res;
        n                  = {1'b0, st_hit};
        mode_next          = st_mode;
        token_len_next     = st_len;
        overflow_seen_next = 1'b0;
      end
      MODE_IDENT, MODE_NUMBER: begin
        if (is_letter || is_digit) begin
          token_len_next     = len_inc;
          overflow_seen_next = ovf_app;
          if (is_letter) mode_next = MODE_IDENT;
          if (app_ok) begin
            r0.text_byte  = char_byte;
            r0.text_valid = 1'b1;
            n             = 2'd1;
          end
        end else begin
          // close the word, then rerun the byte from start unless skipped
          r0.token_end       = 1'b1;
          r0.token_kind      = (mode == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
          r0.token_length    = sat_len(token_len);
          r0.too_long        = overflow_seen;
          overflow_seen_next = 1'b0;
          if (is_other) begin
            n              = 2'd1;
            mode_next      = MODE_START;
            token_len_next = '0;
          end else begin
            r1             = st_res;
            n              = st_hit ? 2'd2 : 2'd1;
            mode_next      = st_mode;
            token_len_next = st_len;
          end
        end
      end
      MODE_STRING: begin
        if (is_eof) begin
          r0.token_end       = 1'b1;
          r0.token_kind      = KIND_EOF;
          r0.token_length    = sat_len(token_len);
          r0.too_long        = overflow_seen;
          n                  = 2'd1;
          mode_next          = MODE_START;
          token_len_next     = '0;
          overflow_seen_next = 1'b0;
        end else if (is_quote) begin
          r0.text_byte       = app_ok ? char_byte : 8'd0;
          r0.text_valid      = app_ok;
          r0.token_end       = 1'b1;
          r0.token_kind      = KIND_STRING;
          r0.token_length    = sat_len(len_inc);
          r0.too_long        = ovf_app;
          n                  = 2'd1;
          mode_next          = MODE_START;
          token_len_next     = '0;
          overflow_seen_next = 1'b0;
        end else begin
          token_len_next     = len_inc;
          overflow_seen_next = ovf_app;
          if (app_ok) begin
            r0.text_byte  = char_byte;
            r0.text_valid = 1'b1;
            n             = 2'd1;
          end
        end
      end
      default: begin
        mode_next          = MODE_START;
        token_len_next     = '0;
        overflow_seen_next = 1'b0;
      end
    endcase
  end

  // Line and column, saturating; end of input leaves them alone
  always_comb begin
    line_count_next   = line_count;
    column_count_next = column_count;
    if (!is_eof) begin
      if (column_count != 16'hFFFF) column_count_next = column_count + 16'd1;
      if (char_byte == CH_NL) begin
        if (line_count != 16'hFFFF) line_count_next = line_count + 16'd1;
        column_count_next = 16'd0;
      end
    end
  end

  // Results for the output queue
  always_comb begin
    push.count                = in_fire ? n : 2'd0;
    push.first.res            = r0;
    push.first.line_number    = line_count_next;
    push.first.column_number  = column_count_next;
    push.first.last_of_run    = (n == 2'd1);
    push.second.res           = r1;
    push.second.line_number   = line_count_next;
    push.second.column_number = column_count_next;
    push.second.last_of_run   = 1'b1;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_START;
      token_len     <= '0;
      overflow_seen <= 1'b0;
      line_count    <= 16'd0;
      column_count  <= 16'd0;
    end else if (in_fire) begin
      mode          <= mode_next;
      token_len     <= token_len_next;
      overflow_seen <= overflow_seen_next;
      line_count    <= line_count_next;
      column_count  <= column_count_next;
    end
  end

endmodule

// ===== sv/tdc_fifo.sv =====
// Four-entry result queue: takes up to two results per cycle from the lexer
// and hands out one beat per cycle while the receiver is ready. Depends on tdc_pkg.
module tdc_fifo (
  input  logic            clk,
  input  logic            rst,
  input  tdc_pkg::push_t  push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output tdc_pkg::entry_t out_entry
);
  import tdc_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  entry_t           store [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_entry = store[rd_ptr];
  // room for a two-result beat
  assign room      = (count <= (PTR_W+1)'(DEPTH - 2));

  // Entry writes
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) store[wr_ptr] <= push.first;
    if (push.count == 2'd2) store[wr_ptr + PTR_W'(1)] <= push.second;
  end

  // Pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count  <= count + (PTR_W+1)'(push.count) - (PTR_W+1)'(pop);
    end
  end

endmodule

// ===== sv/table_driven_config_tokenizer.sv =====
// Top level of the configuration-text tokenizer: lexer plus output queue.
// Depends on tdc_pkg, tdc_lexer and tdc_fifo.
//
//  channel | dir | tdata                     | tuser                          | tlast
//  s_      | in  | char_byte                 | end_of_input                   | -
//  m_      | out | text, length, line, column| text_valid, token_end, kind,   | last_of_run
//          |     |                           | too_long                       |
//
// An input beat is lexed in the cycle it is taken and its zero to two results
// enter a four-entry queue, so the output may show them the next cycle.
// s_tready is high while the queue holds two entries or fewer; throughput is
// one input beat per cycle while m_ does not stall, bounded by the single
// result beat the output port delivers each cycle when inputs yield two results.
// rst (synchronous) returns the lexer to the start state, clears length,
// line and column, and empties the queue. A stall on m_ holds the beat shown.
module table_driven_config_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_byte
  input  logic        s_tuser,   // [0] end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] text_byte, [15:8] token_length,
                                 // [31:16] line_number, [47:32] column_number
  output logic [6:0]  m_tuser,   // [0] text_valid, [1] token_end,
                                 // [5:2] token_kind, [6] too_long
  output logic        m_tlast    // last_of_run
);
  import tdc_pkg::*;

  logic   in_fire;
  push_t  push;
  entry_t head;

  assign in_fire = s_tvalid && s_tready;

  tdc_lexer u_lexer (
    .clk          (clk),
    .rst          (rst),
    .in_fire      (in_fire),
    .char_byte    (s_tdata),
    .end_of_input (s_tuser),
    .push         (push)
  );

  tdc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_entry (head)
  );

  // Output packing
  assign m_tdata = {head.column_number, head.line_number,
                    head.res.token_length, head.res.text_byte};
  assign m_tuser = {head.res.too_long, head.res.token_kind,
                    head.res.token_end, head.res.text_valid};
  assign m_tlast = head.last_of_run;

endmodule

// ===== sv/tdc_checker.sv =====
// Port-level checker for the tokenizer, bound to the top level.
// Depends on tdc_pkg.
module tdc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [6:0]  m_tuser,
  input logic        m_tlast
);
  import tdc_pkg::*;

  // Stalled output beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("output beat changed under stall");

  // Queue is empty after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid straight after reset");

  // End-of-input token carries no text byte
  a_eof: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] && (m_tuser[5:2] == KIND_EOF) |-> !m_tuser[0])
    else $error("eof token with text");

  // Punctuation tokens are one byte, closed in the same beat
  a_punct: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] && (m_tuser[5:2] >= KIND_SEMI) && (m_tuser[5:2] <= KIND_MINUS)
    |-> m_tuser[0] && (m_tdata[15:8] == 8'd1) && !m_tuser[6])
    else $error("malformed punctuation token");

  // A beat that closes no token carries no kind or length
  a_open: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> (m_tuser[6:2] == 5'd0) && (m_tdata[15:8] == 8'd0))
    else $error("kind or length without token end");

endmodule

bind table_driven_config_tokenizer tdc_checker u_tdc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== tb/table_driven_config_tokenizer_tb.sv =====
// Self-checking testbench for the configuration-text tokenizer: drives bytes and
// end marks on the input stream, predicts every result beat and checks the output
// stream field by field. Depends on tdc_pkg and table_driven_config_tokenizer.
module table_driven_config_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tdc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no beat on either side
  localparam int HOLD_CYCLES    = 64;    // long receiver hold-off
  localparam int PRINT_LIMIT    = 40;

  typedef enum int {BC_LETTER, BC_DIGIT, BC_PUNCT, BC_QUOTE, BC_OTHER, BC_EOF} byte_class_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [6:0]  m_tuser;
  logic        m_tlast;

  // Shared controls between the test sequence and the receiver
  logic calm     = 1'b0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;

  // Predictor state
  mode_t       lx_mode = MODE_START;
  int          lx_len  = 0;
  bit          lx_ovf  = 1'b0;
  logic [15:0] lx_line = '0;
  logic [15:0] lx_col  = '0;
  res_t        lex_run[$];
  entry_t      token_beats[$];

  int errors        = 0;
  int items_sent    = 0;
  int beats_checked = 0;
  int tokens_closed = 0;
  int long_tokens   = 0;
  int eof_marks     = 0;

  table_driven_config_tokenizer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic byte_class_t class_of(input logic [7:0] b, input logic eof,
                                           output logic [3:0] pk);
    pk = KIND_IDENT;
    if (eof) return BC_EOF;
    if ((b >= CH_LC_A && b <= CH_LC_Z) || (b >= CH_UC_A && b <= CH_UC_Z)) return BC_LETTER;
    if (b >= CH_0 && b <= CH_9) return BC_DIGIT;
    if (b == CH_QUOTE) return BC_QUOTE;
    case (b)
      CH_SEMI:   pk = KIND_SEMI;
      CH_COMMA:  pk = KIND_COMMA;
      CH_LBRACE: pk = KIND_LBRACE;
      CH_RBRACE: pk = KIND_RBRACE;
      CH_LBRACK: pk = KIND_LBRACK;
      CH_RBRACK: pk = KIND_RBRACK;
      CH_EQUALS: pk = KIND_EQUALS;
      CH_MINUS:  pk = KIND_MINUS;
      default:   return BC_OTHER;
    endcase
    return BC_PUNCT;
  endfunction

  // Extend the token text; 0 when the byte is dropped for length
  function automatic bit grow_text();
    if (lx_len < MAX_TOKEN) begin
      lx_len++;
      return 1'b1;
    end
    lx_ovf = 1'b1;
    return 1'b0;
  endfunction

  function automatic void push_text(input logic [7:0] b);
    res_t r;
    r            = RES_NONE;
    r.text_byte  = b;
    r.text_valid = 1'b1;
    lex_run.push_back(r);
  endfunction

  function automatic void close_token(input logic [3:0] kind, input logic [7:0] b,
                                      input bit with_text);
    res_t r;
    r              = RES_NONE;
    r.text_byte    = with_text ? b : 8'h00;
    r.text_valid   = with_text;
    r.token_end    = 1'b1;
    r.token_kind   = kind;
    r.token_length = (lx_len > 255) ? 8'hFF : lx_len[7:0];
    r.too_long     = lx_ovf;
    lex_run.push_back(r);
    tokens_closed++;
    if (lx_ovf) long_tokens++;
    lx_len  = 0;
    lx_ovf  = 1'b0;
    lx_mode = MODE_START;
  endfunction

  function automatic void lex_from_start(input byte_class_t c, input logic [3:0] pk,
                                         input logic [7:0] b);
    bit kept;
    lx_len  = 0;
    lx_ovf  = 1'b0;
    lx_mode = MODE_START;
    case (c)
      BC_EOF: close_token(KIND_EOF, 8'h00, 1'b0);
      BC_LETTER, BC_DIGIT, BC_QUOTE: begin
        void'(grow_text());
        push_text(b);
        lx_mode = (c == BC_LETTER) ? MODE_IDENT : (c == BC_DIGIT) ? MODE_NUMBER : MODE_STRING;
      end
      BC_PUNCT: begin
        kept = grow_text();
        close_token(pk, b, kept);
      end
      default: ;
    endcase
  endfunction

  // Works out the result beats caused by one accepted input beat
  function automatic void lex_predict(input logic [7:0] b, input logic eof);
    logic [3:0]  pk;
    logic [3:0]  word_kind;
    byte_class_t c;
    bit          kept;
    entry_t      e;
    c = class_of(b, eof, pk);
    lex_run.delete();
    if (!eof) begin
      if (lx_col != 16'hFFFF) lx_col++;
      if (b == CH_NL) begin
        if (lx_line != 16'hFFFF) lx_line++;
        lx_col = '0;
      end
    end
    case (lx_mode)
      MODE_START: lex_from_start(c, pk, b);
      MODE_IDENT, MODE_NUMBER: begin
        if (c == BC_LETTER || c == BC_DIGIT) begin
          if (c == BC_LETTER) lx_mode = MODE_IDENT;
          if (grow_text()) push_text(b);
        end else begin
          word_kind = (lx_mode == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
          close_token(word_kind, 8'h00, 1'b0);
          // a delimiter or end mark is handled again from the start state
          if (c != BC_OTHER) lex_from_start(c, pk, b);
        end
      end
      default: begin
        if (c == BC_EOF) begin
          close_token(KIND_EOF, 8'h00, 1'b0);
        end else if (c == BC_QUOTE) begin
          kept = grow_text();
          close_token(KIND_STRING, b, kept);
        end else if (grow_text()) begin
          push_text(b);
        end
      end
    endcase
    foreach (lex_run[i]) begin
      e.res           = lex_run[i];
      e.line_number   = lx_line;
      e.column_number = lx_col;
      e.last_of_run   = (i == lex_run.size() - 1);
      token_beats.push_back(e);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_LIMIT) $display("[%0t] beat %0d: %s", $realtime, beats_checked, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin : check_beats
    entry_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (token_beats.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, tdata %0h tuser %0h",
                                  m_tdata, m_tuser));
      end else begin
        want = token_beats.pop_front();
        check_field("text_byte",     16'(m_tdata[7:0]),  16'(want.res.text_byte));
        check_field("token_length",  16'(m_tdata[15:8]), 16'(want.res.token_length));
        check_field("line_number",   m_tdata[31:16],     want.line_number);
        check_field("column_number", m_tdata[47:32],     want.column_number);
        check_field("text_valid",    16'(m_tuser[0]),    16'(want.res.text_valid));
        check_field("token_end",     16'(m_tuser[1]),    16'(want.res.token_end));
        check_field("token_kind",    16'(m_tuser[5:2]),  16'(want.res.token_kind));
        check_field("too_long",      16'(m_tuser[6]),    16'(want.res.too_long));
        check_field("last_of_run",   16'(m_tlast),       16'(want.last_of_run));
      end
      beats_checked++;
    end
  end

  // Receiver: random stalls, calm stretches and one long counted hold-off
  initial begin : receiver
    int held;
    held = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_req && !hold_ack) begin
        m_tready <= 1'b0;
        held++;
        if (held >= HOLD_CYCLES) begin
          hold_ack <= 1'b1;
          held = 0;
        end
      end else begin
        if (!hold_req) hold_ack <= 1'b0;
        m_tready <= calm || ($urandom_range(99) >= 11);
      end
    end
  end

  // Watchdog: ends the run when neither side moves for too long
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) stuck = 0;
      else stuck++;
    end
    $display("timeout: no beat for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, token_beats.size());
    $display("table_driven_config_tokenizer_tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  // Offers one input beat, at times with random idle cycles ahead of it
  task automatic send_char(input logic [7:0] b, input logic eof);
    if (!calm && $urandom_range(99) < 11) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= eof;
    do @(posedge clk); while (!s_tready);
    lex_predict(b, eof);
    items_sent++;
    if (eof) eof_marks++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  task automatic send_eof();
    send_char(8'($urandom), 1'b1);
  endtask

  // Sender pause until every expected result has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (token_beats.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] b;
    b = 8'($urandom_range(25));
    return $urandom_range(1) ? CH_LC_A + b : CH_UC_A + b;
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_0 + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_word_char();
    return $urandom_range(2) ? rand_letter() : rand_digit();
  endfunction

  function automatic logic [7:0] rand_punct();
    case ($urandom_range(7))
      0:       return CH_SEMI;
      1:       return CH_COMMA;
      2:       return CH_LBRACE;
      3:       return CH_RBRACE;
      4:       return CH_LBRACK;
      5:       return CH_RBRACK;
      6:       return CH_EQUALS;
      default: return CH_MINUS;
    endcase
  endfunction

  function automatic logic [7:0] rand_non_quote();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CH_QUOTE);
    return b;
  endfunction

  function automatic logic [7:0] rand_other();
    logic [7:0] b;
    logic [3:0] pk;
    do b = 8'($urandom_range(255)); while (class_of(b, 1'b0, pk) != BC_OTHER);
    return b;
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(3))
      0, 1:    return 8'h20;
      2:       return CH_NL;
      default: return rand_other();
    endcase
  endfunction

  // One random token, sometimes broken, an end mark or a stray byte, then at times a separator
  task automatic send_token();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 30) begin
      send_char(rand_letter(), 1'b0);
      n = $urandom_range(7);
      repeat (n) send_char(rand_word_char(), 1'b0);
    end else if (r < 50) begin
      n = $urandom_range(6, 1);
      repeat (n) send_char(rand_digit(), 1'b0);
      if ($urandom_range(9) == 0) send_char(rand_letter(), 1'b0);
    end else if (r < 62) begin
      send_char(CH_QUOTE, 1'b0);
      n = $urandom_range(10);
      repeat (n) send_char(rand_non_quote(), 1'b0);
      // now and then the string is left open
      if ($urandom_range(19) != 0) send_char(CH_QUOTE, 1'b0);
    end else if (r < 85) begin
      send_char(rand_punct(), 1'b0);
    end else if (r < 89) begin
      send_eof();
    end else begin
      send_char(rand_other(), 1'b0);
    end
    if ($urandom_range(1)) send_char(rand_space(), 1'b0);
  endtask

  task automatic send_tokens(input int count);
    int goal;
    goal = items_sent + count;
    while (items_sent < goal) send_token();
  endtask

  // ---------------------------------------------------------------- tests

  // Byte extremes, every token kind and the lexer's special cases apart from length overflow
  task automatic test_directed();
    send_text("aA zZ09;");        // words ended by other byte and by punctuation
    send_text("12x,");            // digits then a letter make an identifier
    send_char(CH_9, 1'b0);
    send_char(CH_QUOTE, 1'b0);    // number closed by a quote that opens a string
    send_char(8'hFF, 1'b0);
    send_char(CH_NL, 1'b0);       // newline kept inside a string
    send_char(CH_QUOTE, 1'b0);
    send_text("=-[]{}");
    send_char(CH_0, 1'b0);
    send_char(8'h00, 1'b0);       // other byte closes a number
    send_char(CH_LC_Z, 1'b0);
    send_eof();                   // end mark after a word
    send_eof();                   // end mark in the start state
    send_char(CH_QUOTE, 1'b0);
    send_char(CH_LC_A, 1'b0);
    send_eof();                   // end mark inside an open string
  endtask

  task automatic test_random_stream();
    send_tokens(180);
  endtask

  // Stretch with no idling on either side
  task automatic test_full_rate();
    calm <= 1'b1;
    send_tokens(70);
    calm <= 1'b0;
  endtask

  // Receiver holds off while the sender keeps offering, so the queue fills up
  task automatic test_receiver_hold();
    hold_req <= 1'b1;
    send_text("alpha=1234;beta");
    send_tokens(25);
    while (!hold_ack) @(posedge clk);
    hold_req <= 1'b0;
    wait_drained();
  endtask

  task automatic test_noise();
    int goal;
    goal = items_sent + 60;
    while (items_sent < goal) begin
      if ($urandom_range(19) == 0) send_eof();
      else send_char(8'($urandom_range(255)), 1'b0);
    end
  endtask

  // Tokens beyond the length limit
  task automatic test_length_limit();
    send_char(rand_letter(), 1'b0);
    repeat (MAX_TOKEN + 1) send_char(rand_word_char(), 1'b0);
    send_char(CH_SEMI, 1'b0);
    // string whose closing quote no longer fits
    send_char(CH_QUOTE, 1'b0);
    repeat (MAX_TOKEN - 1) send_char(rand_non_quote(), 1'b0);
    send_char(CH_QUOTE, 1'b0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_stream();
    test_full_rate();
    test_receiver_hold();
    test_noise();
    wait_drained();
    test_length_limit();
    send_tokens(40);
    wait_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d input beats (%0d end marks), %0d result beats, %0d tokens",
             items_sent, eof_marks, beats_checked, tokens_closed);
    $display("incl. %0d over-length tokens and a long output hold-off", long_tokens);
    if (errors == 0 && token_beats.size() == 0) begin
      $display("table_driven_config_tokenizer_tb OK");
    end else begin
      $display("table_driven_config_tokenizer_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tdc_pkg.sv
sv/tdc_lexer.sv
sv/tdc_fifo.sv
sv/table_driven_config_tokenizer.sv
sv/tdc_checker.sv
tb/table_driven_config_tokenizer_tb.sv
